>>> design/ilda_stream_parser_unit_macros.svh
// ----------------------------------------------------------------------------
// ilda_stream_parser_unit_macros.svh
// Assertion helper macros for the ILDA stream parser.
// ----------------------------------------------------------------------------
`ifndef ILDA_STREAM_PARSER_UNIT_MACROS_SVH
`define ILDA_STREAM_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ILDA_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("ilda_sp assertion failed");
// next-cycle implication
`define ILDA_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("ilda_sp assertion failed");
`else
`define ILDA_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define ILDA_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif

`endif

>>> design/ilda_sp_pkg.sv
// ----------------------------------------------------------------------------
// ilda_sp_pkg
// Shared types, codes and helpers for the ILDA stream parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ilda_sp_pkg;

  localparam logic [4:0] HDR_LAST_POS   = 5'd31;
  localparam logic [4:0] HDR_FORMAT_POS = 5'd7;
  localparam logic [4:0] HDR_COUNT_HI   = 5'd24;
  localparam logic [4:0] HDR_COUNT_LO   = 5'd25;
  localparam logic [4:0] HDR_FRAME_HI   = 5'd26;
  localparam logic [4:0] HDR_FRAME_LO   = 5'd27;
  localparam logic [4:0] HDR_TOTAL_HI   = 5'd28;
  localparam logic [4:0] HDR_TOTAL_LO   = 5'd29;
  localparam logic [4:0] HDR_PROJ_POS   = 5'd30;

  localparam int unsigned ASM_DEPTH = 9;

  // result kinds
  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_POINT   = 3'd1;
  localparam logic [2:0] KIND_PALETTE = 3'd2;
  localparam logic [2:0] KIND_END     = 3'd3;
  localparam logic [2:0] KIND_BAD     = 3'd4;

  // section format codes
  localparam logic [7:0] FMT_IDX_3D  = 8'd0;
  localparam logic [7:0] FMT_IDX_2D  = 8'd1;
  localparam logic [7:0] FMT_PALETTE = 8'd2;
  localparam logic [7:0] FMT_TC_3D   = 8'd4;
  localparam logic [7:0] FMT_TC_2D   = 8'd5;

  typedef enum logic [2:0] {
    PH_HDR = 3'b001,
    PH_REC = 3'b010,
    PH_ERR = 3'b100
  } ilda_phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] coord_x;
    logic [15:0] coord_y;
    logic [15:0] coord_z;
    logic [7:0]  status_bits;
    logic [7:0]  colour_index;
    logic [23:0] colour_rgb;
    logic [7:0]  format_kind;
    logic [15:0] record_total;
    logic [15:0] frame_index;
    logic [15:0] frame_total;
    logic [7:0]  projector_id;
  } ilda_res_t;

  // bytes per record, zero for an unknown format
  function automatic logic [3:0] rec_size(input logic [7:0] fmt);
    logic [3:0] sz;
    case (fmt)
      FMT_IDX_3D:  sz = 4'd8;
      FMT_IDX_2D:  sz = 4'd6;
      FMT_PALETTE: sz = 4'd3;
      FMT_TC_3D:   sz = 4'd10;
      FMT_TC_2D:   sz = 4'd8;
      default:     sz = 4'd0;
    endcase
    return sz;
  endfunction

endpackage

>>> design/ilda_sp_in_reg.sv
// ----------------------------------------------------------------------------
// ilda_sp_in_reg
// Input byte register; holds one byte until the parser takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilda_sp_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_data_byte,
  output logic       in_stall,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);
  import ilda_sp_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       take;

  // refill when empty or when the held byte moves on this cycle
  assign in_stall = valid_r & ~advance;
  assign take     = in_valid & ~in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_data_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = data_r;

endmodule

>>> design/ilda_sp_parse.sv
// ----------------------------------------------------------------------------
// ilda_sp_parse
// Section state and byte decode: header fields, record assembly, results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ilda_stream_parser_unit_macros.svh"

module ilda_sp_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [7:0]             b,
  output logic                   res_valid,
  output ilda_sp_pkg::ilda_res_t res
);
  import ilda_sp_pkg::*;

  ilda_phase_t phase_r, phase_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [15:0] left_r, left_nxt;
  logic [7:0]  fmt_r, fmt_nxt;
  logic [7:0]  pal_r, pal_nxt;
  logic [7:0]  asm_r [ASM_DEPTH];
  logic [7:0]  asm_nxt [ASM_DEPTH];
  logic [15:0] frame_r, frame_nxt;
  logic [15:0] total_r, total_nxt;
  logic [3:0]  size;

  assign size = rec_size(fmt_r);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    left_nxt  = left_r;
    fmt_nxt   = fmt_r;
    pal_nxt   = pal_r;
    frame_nxt = frame_r;
    total_nxt = total_r;
    for (int i = 0; i < ASM_DEPTH; i++) begin
      asm_nxt[i] = asm_r[i];
    end
    res_valid = 1'b0;
    res       = '0;

    if (step) begin
      case (phase_r)
        PH_HDR: begin
          case (pos_r)
            HDR_FORMAT_POS: fmt_nxt   = b;
            HDR_COUNT_HI:   left_nxt  = {b, 8'h00};
            HDR_COUNT_LO:   left_nxt  = {left_r[15:8], b};
            HDR_FRAME_HI:   frame_nxt = {b, 8'h00};
            HDR_FRAME_LO:   frame_nxt = {frame_r[15:8], b};
            HDR_TOTAL_HI:   total_nxt = {b, 8'h00};
            HDR_TOTAL_LO:   total_nxt = {total_r[15:8], b};
            HDR_PROJ_POS:   asm_nxt[0] = b;
            default: ;
          endcase
          if (pos_r != HDR_LAST_POS) begin
            pos_nxt = pos_r + 5'd1;
          end else begin
            pos_nxt          = '0;
            res_valid        = 1'b1;
            res.format_kind  = fmt_r;
            res.record_total = left_r;
            res.frame_index  = frame_r;
            res.frame_total  = total_r;
            res.projector_id = asm_r[0];
            if (left_r == 16'd0) begin
              res.kind = KIND_END;
            end else if (size != 4'd0) begin
              res.kind  = KIND_HEADER;
              phase_nxt = PH_REC;
              if (fmt_r == FMT_PALETTE) begin
                pal_nxt = '0;
              end
            end else begin
              res.kind  = KIND_BAD;
              phase_nxt = PH_ERR;
            end
          end
        end
        PH_REC: begin
          if (pos_r[3:0] != size - 4'd1) begin
            for (int i = 0; i < ASM_DEPTH; i++) begin
              if (pos_r[3:0] == 4'(i)) begin
                asm_nxt[i] = b;
              end
            end
            pos_nxt = pos_r + 5'd1;
          end else begin
            // last byte of the record comes straight from the input
            pos_nxt         = '0;
            res_valid       = 1'b1;
            res.format_kind = fmt_r;
            res.kind        = KIND_POINT;
            res.coord_x     = {asm_r[0], asm_r[1]};
            case (fmt_r)
              FMT_IDX_3D: begin
                res.coord_y      = {asm_r[2], asm_r[3]};
                res.coord_z      = {asm_r[4], asm_r[5]};
                res.status_bits  = asm_r[6];
                res.colour_index = b;
              end
              FMT_IDX_2D: begin
                res.coord_y      = {asm_r[2], asm_r[3]};
                res.status_bits  = asm_r[4];
                res.colour_index = b;
              end
              FMT_PALETTE: begin
                res.kind         = KIND_PALETTE;
                res.coord_x      = '0;
                res.colour_index = pal_r;
                res.colour_rgb   = {asm_r[0], asm_r[1], b};
                pal_nxt          = pal_r + 8'd1;
              end
              FMT_TC_3D: begin
                res.coord_y     = {asm_r[2], asm_r[3]};
                res.coord_z     = {asm_r[4], asm_r[5]};
                res.status_bits = asm_r[6];
                res.colour_rgb  = {b, asm_r[8], asm_r[7]};
              end
              default: begin
                res.coord_y     = {asm_r[2], asm_r[3]};
                res.status_bits = asm_r[4];
                res.colour_rgb  = {b, asm_r[6], asm_r[5]};
              end
            endcase
            left_nxt = left_r - 16'd1;
            if (left_r == 16'd1) begin
              phase_nxt = PH_HDR;
            end
          end
        end
        PH_ERR: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      pos_r   <= '0;
      left_r  <= '0;
      fmt_r   <= '0;
      pal_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      left_r  <= left_nxt;
      fmt_r   <= fmt_nxt;
      pal_r   <= pal_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    total_r <= total_nxt;
    for (int i = 0; i < ASM_DEPTH; i++) begin
      asm_r[i] <= asm_nxt[i];
    end
  end

  `ILDA_ASSERT_NXT(a_err_sticky, clk, rst_n, phase_r == PH_ERR, phase_r == PH_ERR)
  `ILDA_ASSERT_IMP(a_err_silent, clk, rst_n, phase_r == PH_ERR, !res_valid)
  `ILDA_ASSERT_IMP(a_rec_pos, clk, rst_n, phase_r == PH_REC, pos_r < 5'd10)
  `ILDA_ASSERT_NXT(a_hdr_enters_rec, clk, rst_n,
                   res_valid && res.kind == KIND_HEADER, phase_r == PH_REC)

endmodule

>>> design/ilda_sp_out_reg.sv
// ----------------------------------------------------------------------------
// ilda_sp_out_reg
// Result register; holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilda_sp_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_valid,
  input  ilda_sp_pkg::ilda_res_t res,
  output logic                   advance,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ilda_sp_pkg::ilda_res_t out_res
);
  import ilda_sp_pkg::*;

  logic      valid_r, valid_nxt;
  ilda_res_t res_r;

  // parser may step when the slot is empty or is being transferred now
  assign advance = ~valid_r | ~out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

>>> design/ilda_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// ilda_stream_parser_unit: ILDA byte stream parser, one byte per cycle at most.
// Flow: the byte that completes a result is held in the input register, then
// decoded into the result register, which raises out_valid. Throughput:
// 1 byte per cycle unless stalled, set by the input and result registers.
// Reset: synchronous rst_n; clears phase, counters and both valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ilda_stream_parser_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         in_data_byte,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_kind,
  output logic signed [15:0] out_coord_x,
  output logic signed [15:0] out_coord_y,
  output logic signed [15:0] out_coord_z,
  output logic [7:0]         out_status_bits,
  output logic [7:0]         out_colour_index,
  output logic [23:0]        out_colour_rgb,
  output logic [7:0]         out_format_kind,
  output logic [15:0]        out_record_total,
  output logic [15:0]        out_frame_index,
  output logic [15:0]        out_frame_total,
  output logic [7:0]         out_projector_id
);
  import ilda_sp_pkg::*;

  logic      advance;
  logic      byte_valid;
  logic [7:0] byte_data;
  logic      res_valid;
  ilda_res_t res;
  ilda_res_t out_res;

  ilda_sp_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_stall     (in_stall),
    .advance      (advance),
    .byte_valid   (byte_valid),
    .byte_data    (byte_data)
  );

  ilda_sp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (byte_valid & advance),
    .b         (byte_data),
    .res_valid (res_valid),
    .res       (res)
  );

  ilda_sp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind         = out_res.kind;
  assign out_coord_x      = signed'(out_res.coord_x);
  assign out_coord_y      = signed'(out_res.coord_y);
  assign out_coord_z      = signed'(out_res.coord_z);
  assign out_status_bits  = out_res.status_bits;
  assign out_colour_index = out_res.colour_index;
  assign out_colour_rgb   = out_res.colour_rgb;
  assign out_format_kind  = out_res.format_kind;
  assign out_record_total = out_res.record_total;
  assign out_frame_index  = out_res.frame_index;
  assign out_frame_total  = out_res.frame_total;
  assign out_projector_id = out_res.projector_id;

endmodule
